FILE: rtl/lmqts_pkg.sv
// shared types and codes for the locked multi-queue task sequencer
package lmqts_pkg;

	// operation codes
	localparam logic [2:0] OP_SCHEDULE    = 3'd0;
	localparam logic [2:0] OP_SPACES      = 3'd1;
	localparam logic [2:0] OP_POOL_COUNT  = 3'd2;
	localparam logic [2:0] OP_PROCESSABLE = 3'd3;
	localparam logic [2:0] OP_POP_POOL    = 3'd4;
	localparam logic [2:0] OP_POP_SEQ     = 3'd5;
	localparam logic [2:0] OP_UNLOCK      = 3'd6;

	// result status codes
	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_STORAGE_FULL = 3'd1;
	localparam logic [2:0] STAT_QUEUE_FULL   = 3'd2;
	localparam logic [2:0] STAT_INVALID      = 3'd3;
	localparam logic [2:0] STAT_LOCKED       = 3'd4;
	localparam logic [2:0] STAT_EMPTY        = 3'd5;

	// queue id that selects the shared pool
	localparam logic [7:0] POOL_ID = 8'd255;

	// one input beat
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] queue_id;
		logic [7:0] task_id;
		logic       storage_has_space;
	} item_t;

	// one result beat
	typedef struct packed {
		logic       success;
		logic [2:0] status;
		logic [7:0] popped_task;
		logic [7:0] count;
	} result_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} fsm_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

FILE: rtl/locked_multi_queue_task_sequencer_core.sv
// Locked multi-queue task sequencer: one shared pool fifo and NUM_SEQUENCES
// sequence fifos with lock bits. An item is taken when start is high and busy
// is low; its result is registered in the execute state and appears on result
// with done high for one cycle, and cannot be held off. Busy is high only in
// the cycle after acceptance, so a new item may be started in the cycle its
// predecessor's result is shown. Storage contents need no clearing after
// reset; the block is ready as soon as reset is released.
module locked_multi_queue_task_sequencer_core #(
	parameter int NUM_SEQUENCES  = 4,
	parameter int SEQUENCE_DEPTH = 16,
	parameter int POOL_DEPTH     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lmqts_pkg::item_t     item,
	output logic                 done,
	output lmqts_pkg::result_t   result
);

	lmqts_pkg::ctrl_cmd_t cmd;

	// sequencing
	lmqts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// queues and result
	lmqts_dp #(
		.NUM_SEQUENCES  (NUM_SEQUENCES),
		.SEQUENCE_DEPTH (SEQUENCE_DEPTH),
		.POOL_DEPTH     (POOL_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

FILE: rtl/lmqts_ctrl.sv
// controller state machine: accept, execute, present result
module lmqts_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	output lmqts_pkg::ctrl_cmd_t   cmd
);

	lmqts_pkg::fsm_state_t state_q;
	lmqts_pkg::fsm_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmqts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		done        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			lmqts_pkg::S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = lmqts_pkg::S_EXEC;
				end
			end
			lmqts_pkg::S_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				state_d     = lmqts_pkg::S_DONE;
			end
			lmqts_pkg::S_DONE: begin
				done = 1'b1;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = lmqts_pkg::S_EXEC;
				end else begin
					state_d = lmqts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lmqts_pkg::S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// every executed beat is presented in the following cycle
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> done)
		else $error("execute not followed by result strobe");

	// no capture while an item is executing
	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.capture)
		else $error("item captured while busy");

	// a result strobe only follows execution
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.execute))
		else $error("result strobe without execution");
`endif

endmodule

FILE: rtl/lmqts_dp.sv
// datapath: pool and sequence fifos, lock bits, result registers
module lmqts_dp #(
	parameter int NUM_SEQUENCES  = 4,
	parameter int SEQUENCE_DEPTH = 16,
	parameter int POOL_DEPTH     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lmqts_pkg::ctrl_cmd_t   cmd,
	input  lmqts_pkg::item_t       item,
	output lmqts_pkg::result_t     result
);

	localparam int SW        = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
	localparam int PW        = $clog2(SEQUENCE_DEPTH);
	localparam int FW        = $clog2(SEQUENCE_DEPTH + 1);
	localparam int QW        = $clog2(POOL_DEPTH);
	localparam int QFW       = $clog2(POOL_DEPTH + 1);
	localparam int SEQ_WORDS = NUM_SEQUENCES * (1 << PW);

	// captured item
	lmqts_pkg::item_t item_q;

	// queue bookkeeping
	logic [QW-1:0]            pool_rd_ptr_q;
	logic [QFW-1:0]           pool_fill_q;
	logic [PW-1:0]            seq_rd_ptr_q [NUM_SEQUENCES];
	logic [FW-1:0]            seq_fill_q   [NUM_SEQUENCES];
	logic [NUM_SEQUENCES-1:0] unlocked_q;

	// storage
	logic [7:0] pool_mem [POOL_DEPTH];
	logic [7:0] seq_mem  [SEQ_WORDS];
	logic [7:0] pool_rdata_q;
	logic [7:0] seq_rdata_q;

	// registered result
	logic       success_q;
	logic [2:0] status_q;
	logic [7:0] count_q;
	logic       pop_pool_q;
	logic       pop_seq_q;

	// decode
	logic          is_pool;
	logic          is_seq;
	logic [SW-1:0] qid_idx;
	logic [PW-1:0] seq_rd_sel;
	logic [FW-1:0] seq_fill_sel;
	logic          seq_unl_sel;

	// decisions
	logic       res_success;
	logic [2:0] res_status;
	logic [7:0] res_count;
	logic       do_pool_wr;
	logic       do_seq_wr;
	logic       do_pool_pop;
	logic       do_seq_pop;
	logic       do_unlock;

	// write positions
	logic [QW:0]   pool_sum;
	logic [QW-1:0] pool_wr_pos;
	logic [PW:0]   seq_sum;
	logic [PW-1:0] seq_wr_pos;

	// capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// id decode and selected sequence state
	always_comb begin
		is_pool      = (item_q.queue_id == lmqts_pkg::POOL_ID);
		is_seq       = (item_q.queue_id < 8'(NUM_SEQUENCES));
		qid_idx      = item_q.queue_id[SW-1:0];
		seq_rd_sel   = seq_rd_ptr_q[qid_idx];
		seq_fill_sel = seq_fill_q[qid_idx];
		seq_unl_sel  = unlocked_q[qid_idx];
	end

	// tail positions, wrapped once
	always_comb begin
		pool_sum    = (QW+1)'(pool_rd_ptr_q) + (QW+1)'(pool_fill_q);
		pool_wr_pos = (pool_sum >= (QW+1)'(POOL_DEPTH)) ?
			QW'(pool_sum - (QW+1)'(POOL_DEPTH)) : QW'(pool_sum);
		seq_sum     = (PW+1)'(seq_rd_sel) + (PW+1)'(seq_fill_sel);
		seq_wr_pos  = (seq_sum >= (PW+1)'(SEQUENCE_DEPTH)) ?
			PW'(seq_sum - (PW+1)'(SEQUENCE_DEPTH)) : PW'(seq_sum);
	end

	// operation decision
	always_comb begin
		res_success = 1'b0;
		res_status  = lmqts_pkg::STAT_INVALID;
		res_count   = 8'd0;
		do_pool_wr  = 1'b0;
		do_seq_wr   = 1'b0;
		do_pool_pop = 1'b0;
		do_seq_pop  = 1'b0;
		do_unlock   = 1'b0;
		unique case (item_q.operation)
			lmqts_pkg::OP_SCHEDULE: begin
				priority if (!item_q.storage_has_space) begin
					res_status = lmqts_pkg::STAT_STORAGE_FULL;
				end else if (is_pool) begin
					if (pool_fill_q == QFW'(POOL_DEPTH)) begin
						res_status = lmqts_pkg::STAT_QUEUE_FULL;
					end else begin
						res_success = 1'b1;
						res_status  = lmqts_pkg::STAT_OK;
						do_pool_wr  = 1'b1;
					end
				end else if (is_seq) begin
					if (seq_fill_sel == FW'(SEQUENCE_DEPTH)) begin
						res_status = lmqts_pkg::STAT_QUEUE_FULL;
					end else begin
						res_success = 1'b1;
						res_status  = lmqts_pkg::STAT_OK;
						do_seq_wr   = 1'b1;
					end
				end else begin
					res_status = lmqts_pkg::STAT_INVALID;
				end
			end
			lmqts_pkg::OP_SPACES: begin
				priority if (!item_q.storage_has_space) begin
					res_status = lmqts_pkg::STAT_STORAGE_FULL;
				end else if (is_pool) begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
					res_count   = 8'(QFW'(POOL_DEPTH) - pool_fill_q);
				end else if (is_seq) begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
					res_count   = 8'(FW'(SEQUENCE_DEPTH) - seq_fill_sel);
				end else begin
					res_status = lmqts_pkg::STAT_INVALID;
				end
			end
			lmqts_pkg::OP_POOL_COUNT: begin
				res_success = 1'b1;
				res_status  = lmqts_pkg::STAT_OK;
				res_count   = 8'(pool_fill_q);
			end
			lmqts_pkg::OP_PROCESSABLE: begin
				priority if (!is_seq) begin
					res_status = lmqts_pkg::STAT_INVALID;
				end else if (!seq_unl_sel) begin
					res_status = lmqts_pkg::STAT_LOCKED;
				end else if (seq_fill_sel == '0) begin
					res_status = lmqts_pkg::STAT_EMPTY;
				end else begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
				end
			end
			lmqts_pkg::OP_POP_POOL: begin
				if (pool_fill_q == '0) begin
					res_status = lmqts_pkg::STAT_EMPTY;
				end else begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
					do_pool_pop = 1'b1;
				end
			end
			lmqts_pkg::OP_POP_SEQ: begin
				priority if (!is_seq) begin
					res_status = lmqts_pkg::STAT_INVALID;
				end else if (!seq_unl_sel) begin
					res_status = lmqts_pkg::STAT_LOCKED;
				end else if (seq_fill_sel == '0) begin
					res_status = lmqts_pkg::STAT_EMPTY;
				end else begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
					do_seq_pop  = 1'b1;
				end
			end
			lmqts_pkg::OP_UNLOCK: begin
				if (is_seq) begin
					res_success = 1'b1;
					res_status  = lmqts_pkg::STAT_OK;
					do_unlock   = 1'b1;
				end
			end
			default: begin
				res_status = lmqts_pkg::STAT_INVALID;
			end
		endcase
	end

	// pointer, fill and lock updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_rd_ptr_q <= '0;
			pool_fill_q   <= '0;
			unlocked_q    <= '1;
			for (int i = 0; i < NUM_SEQUENCES; i++) begin
				seq_rd_ptr_q[i] <= '0;
				seq_fill_q[i]   <= '0;
			end
		end else if (cmd.execute) begin
			if (do_pool_wr) begin
				pool_fill_q <= pool_fill_q + QFW'(1);
			end
			if (do_pool_pop) begin
				pool_fill_q   <= pool_fill_q - QFW'(1);
				pool_rd_ptr_q <= (pool_rd_ptr_q == QW'(POOL_DEPTH - 1)) ?
					'0 : pool_rd_ptr_q + QW'(1);
			end
			if (do_seq_wr) begin
				seq_fill_q[qid_idx] <= seq_fill_sel + FW'(1);
			end
			if (do_seq_pop) begin
				seq_fill_q[qid_idx]   <= seq_fill_sel - FW'(1);
				seq_rd_ptr_q[qid_idx] <= (seq_rd_sel == PW'(SEQUENCE_DEPTH - 1)) ?
					'0 : seq_rd_sel + PW'(1);
				unlocked_q[qid_idx]   <= 1'b0;
			end
			if (do_unlock) begin
				unlocked_q[qid_idx] <= 1'b1;
			end
		end
	end

	// pool storage: tail write, head read
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (do_pool_wr) begin
				pool_mem[pool_wr_pos] <= item_q.task_id;
			end
			pool_rdata_q <= pool_mem[pool_rd_ptr_q];
		end
	end

	// sequence storage: one region per sequence
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (do_seq_wr) begin
				seq_mem[{qid_idx, seq_wr_pos}] <= item_q.task_id;
			end
			seq_rdata_q <= seq_mem[{qid_idx, seq_rd_sel}];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			success_q  <= res_success;
			status_q   <= res_status;
			count_q    <= res_count;
			pop_pool_q <= do_pool_pop;
			pop_seq_q  <= do_seq_pop;
		end
	end

	// result beat
	always_comb begin
		result.success     = success_q;
		result.status      = status_q;
		result.count       = count_q;
		result.popped_task = pop_pool_q ? pool_rdata_q :
			(pop_seq_q ? seq_rdata_q : 8'd0);
	end

`ifndef ASSERT_OFF
	// pool occupancy never passes its depth
	a_pool_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		pool_fill_q <= QFW'(POOL_DEPTH))
		else $error("pool fill beyond depth");

	// bookkeeping only moves on an executed item
	a_pool_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(pool_fill_q != $past(pool_fill_q)) |-> $past(cmd.execute))
		else $error("pool fill changed without execution");

	// a pop that took an entry reports success with status ok
	a_pop_success: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && (do_pool_pop || do_seq_pop) |=>
			result.success && (result.status == lmqts_pkg::STAT_OK))
		else $error("pop result not marked successful");
`endif

endmodule

FILE: tb/locked_multi_queue_task_sequencer_core_tb.sv
// self-checking testbench for the locked multi-queue task sequencer core
module locked_multi_queue_task_sequencer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SEQ      = 4;
	localparam int SEQ_DEPTH    = 16;
	localparam int POOL_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 1325;
	localparam int PHASE_LEN    = 150;

	// operation code the block does not define
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// mirror of the queues and lock bits, plus the outcomes still owed by the block
	class sequencer_scoreboard;
		logic [7:0]          pool_mem [POOL_DEPTH];
		int unsigned         pool_head;
		int unsigned         pool_fill;
		logic [7:0]          seq_mem [NUM_SEQ][SEQ_DEPTH];
		int unsigned         seq_head [NUM_SEQ];
		int unsigned         seq_fill [NUM_SEQ];
		bit                  seq_open [NUM_SEQ];
		lmqts_pkg::result_t  outcome_q [$];
		int                  errors;
		int                  checked;
		int                  status_seen [8];

		function new();
			pool_head = 0;
			pool_fill = 0;
			errors = 0;
			checked = 0;
			foreach (seq_head[s]) begin
				seq_head[s] = 0;
				seq_fill[s] = 0;
				seq_open[s] = 1'b1;
			end
			foreach (status_seen[k]) status_seen[k] = 0;
		endfunction

		function lmqts_pkg::result_t reply(bit ok, logic [2:0] st, logic [7:0] popped,
				logic [7:0] cnt);
			lmqts_pkg::result_t r;
			r.success = ok;
			r.status = st;
			r.popped_task = popped;
			r.count = cnt;
			return r;
		endfunction

		// work out the outcome of one operation and update the mirrored queues
		function lmqts_pkg::result_t predict_outcome(lmqts_pkg::item_t it);
			bit          is_pool;
			bit          is_seq;
			int unsigned q;
			logic [7:0]  val;
			is_pool = (it.queue_id == lmqts_pkg::POOL_ID);
			is_seq = (it.queue_id < NUM_SEQ);
			q = it.queue_id;
			case (it.operation)
				lmqts_pkg::OP_SCHEDULE: begin
					if (!it.storage_has_space) begin
						return reply(1'b0, lmqts_pkg::STAT_STORAGE_FULL, 8'd0, 8'd0);
					end else if (is_pool) begin
						if (pool_fill >= POOL_DEPTH)
							return reply(1'b0, lmqts_pkg::STAT_QUEUE_FULL, 8'd0, 8'd0);
						pool_mem[(pool_head + pool_fill) % POOL_DEPTH] = it.task_id;
						pool_fill++;
						return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0, 8'd0);
					end else if (is_seq) begin
						if (seq_fill[q] >= SEQ_DEPTH)
							return reply(1'b0, lmqts_pkg::STAT_QUEUE_FULL, 8'd0, 8'd0);
						seq_mem[q][(seq_head[q] + seq_fill[q]) % SEQ_DEPTH] = it.task_id;
						seq_fill[q]++;
						return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0, 8'd0);
					end
					return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
				end
				lmqts_pkg::OP_SPACES: begin
					if (!it.storage_has_space)
						return reply(1'b0, lmqts_pkg::STAT_STORAGE_FULL, 8'd0, 8'd0);
					if (is_pool)
						return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0,
							8'(POOL_DEPTH - pool_fill));
					if (is_seq)
						return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0,
							8'(SEQ_DEPTH - seq_fill[q]));
					return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
				end
				lmqts_pkg::OP_POOL_COUNT: begin
					return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0, 8'(pool_fill));
				end
				lmqts_pkg::OP_PROCESSABLE: begin
					if (!is_seq)
						return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
					if (!seq_open[q])
						return reply(1'b0, lmqts_pkg::STAT_LOCKED, 8'd0, 8'd0);
					if (seq_fill[q] == 0)
						return reply(1'b0, lmqts_pkg::STAT_EMPTY, 8'd0, 8'd0);
					return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0, 8'd0);
				end
				lmqts_pkg::OP_POP_POOL: begin
					if (pool_fill == 0)
						return reply(1'b0, lmqts_pkg::STAT_EMPTY, 8'd0, 8'd0);
					val = pool_mem[pool_head];
					pool_head = (pool_head + 1) % POOL_DEPTH;
					pool_fill--;
					return reply(1'b1, lmqts_pkg::STAT_OK, val, 8'd0);
				end
				lmqts_pkg::OP_POP_SEQ: begin
					if (!is_seq)
						return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
					if (!seq_open[q])
						return reply(1'b0, lmqts_pkg::STAT_LOCKED, 8'd0, 8'd0);
					if (seq_fill[q] == 0)
						return reply(1'b0, lmqts_pkg::STAT_EMPTY, 8'd0, 8'd0);
					val = seq_mem[q][seq_head[q]];
					seq_head[q] = (seq_head[q] + 1) % SEQ_DEPTH;
					seq_fill[q]--;
					seq_open[q] = 1'b0;
					return reply(1'b1, lmqts_pkg::STAT_OK, val, 8'd0);
				end
				lmqts_pkg::OP_UNLOCK: begin
					if (!is_seq)
						return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
					seq_open[q] = 1'b1;
					return reply(1'b1, lmqts_pkg::STAT_OK, 8'd0, 8'd0);
				end
				default: begin
					return reply(1'b0, lmqts_pkg::STAT_INVALID, 8'd0, 8'd0);
				end
			endcase
		endfunction

		function void note_item(lmqts_pkg::item_t it);
			outcome_q.push_back(predict_outcome(it));
		endfunction

		// compare one result beat with the oldest owed outcome
		function void check_result(lmqts_pkg::result_t got);
			lmqts_pkg::result_t want;
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %p", $time, got);
				return;
			end
			want = outcome_q.pop_front();
			checked++;
			status_seen[want.status]++;
			if (got.success !== want.success || got.status !== want.status ||
					got.popped_task !== want.popped_task || got.count !== want.count) begin
				errors++;
				// fields in order: ok, status, task, count
				$display("%0t: mismatch, expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
					$time, want.success, want.status, want.popped_task, want.count,
					got.success, got.status, got.popped_task, got.count);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	lmqts_pkg::item_t   item;
	logic               done;
	lmqts_pkg::result_t result;

	sequencer_scoreboard sb;
	int n_sent;

	locked_multi_queue_task_sequencer_core #(
		.NUM_SEQUENCES (NUM_SEQ),
		.SEQUENCE_DEPTH(SEQ_DEPTH),
		.POOL_DEPTH    (POOL_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watch both sides of the block at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
		end
	end

	function automatic lmqts_pkg::item_t mk(logic [2:0] op, logic [7:0] qid,
			logic [7:0] tidx, bit room);
		lmqts_pkg::item_t it;
		it.operation = op;
		it.queue_id = qid;
		it.task_id = tidx;
		it.storage_has_space = room;
		return it;
	endfunction

	// random operation, biased towards filling or draining the queues
	function automatic lmqts_pkg::item_t random_item(bit filling, int focus);
		lmqts_pkg::item_t it;
		int               pick;
		it.task_id = 8'($urandom_range(255));
		it.storage_has_space = ($urandom_range(99) < 90);
		pick = $urandom_range(99);
		if (pick < 35)
			it.queue_id = lmqts_pkg::POOL_ID;
		else if (pick < 55 && filling)
			it.queue_id = 8'(focus);
		else if (pick < 88)
			it.queue_id = 8'($urandom_range(NUM_SEQ - 1));
		else
			it.queue_id = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (filling) begin
			if (pick < 55)      it.operation = lmqts_pkg::OP_SCHEDULE;
			else if (pick < 62) it.operation = lmqts_pkg::OP_SPACES;
			else if (pick < 67) it.operation = lmqts_pkg::OP_POOL_COUNT;
			else if (pick < 75) it.operation = lmqts_pkg::OP_PROCESSABLE;
			else if (pick < 82) it.operation = lmqts_pkg::OP_POP_POOL;
			else if (pick < 90) it.operation = lmqts_pkg::OP_POP_SEQ;
			else if (pick < 98) it.operation = lmqts_pkg::OP_UNLOCK;
			else                it.operation = OP_UNUSED;
		end else begin
			if (pick < 15)      it.operation = lmqts_pkg::OP_SCHEDULE;
			else if (pick < 22) it.operation = lmqts_pkg::OP_SPACES;
			else if (pick < 27) it.operation = lmqts_pkg::OP_POOL_COUNT;
			else if (pick < 37) it.operation = lmqts_pkg::OP_PROCESSABLE;
			else if (pick < 57) it.operation = lmqts_pkg::OP_POP_POOL;
			else if (pick < 77) it.operation = lmqts_pkg::OP_POP_SEQ;
			else if (pick < 97) it.operation = lmqts_pkg::OP_UNLOCK;
			else                it.operation = OP_UNUSED;
		end
		return it;
	endfunction

	// present one beat, maybe after a short gap, and hold it until taken
	task automatic drive_item(input lmqts_pkg::item_t it, input bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(99) < 22)
			gap = $urandom_range(2, 1);
		@(negedge clk);
		repeat (gap) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	// run limit
	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		lmqts_pkg::item_t directed [$];
		bit               filling;
		int               focus;
		int               waited;
		sb = new();
		n_sent = 0;
		filling = 1'b0;
		focus = 0;
		waited = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, undefined code, every failure status but queue full, field extremes
		directed.push_back(mk(lmqts_pkg::OP_POOL_COUNT, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(OP_UNUSED, 8'hFF, 8'hFF, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, lmqts_pkg::POOL_ID, 8'h5A, 1'b0));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, 8'(NUM_SEQ), 8'h01, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, 8'd254, 8'h02, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, lmqts_pkg::POOL_ID, 8'hFF, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, lmqts_pkg::POOL_ID, 8'h00, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, 8'd0, 8'hA5, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SCHEDULE, 8'(NUM_SEQ - 1), 8'h5A, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SPACES, lmqts_pkg::POOL_ID, 8'd0, 1'b0));
		directed.push_back(mk(lmqts_pkg::OP_SPACES, 8'h80, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SPACES, lmqts_pkg::POOL_ID, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_SPACES, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_PROCESSABLE, lmqts_pkg::POOL_ID, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_PROCESSABLE, 8'd1, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_PROCESSABLE, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_SEQ, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_PROCESSABLE, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_SEQ, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_SEQ, 8'd200, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_SEQ, 8'd2, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_UNLOCK, 8'hFF, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_UNLOCK, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_POOL, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_POOL, 8'd0, 8'd0, 1'b1));
		directed.push_back(mk(lmqts_pkg::OP_POP_POOL, 8'd0, 8'd0, 1'b1));
		foreach (directed[i])
			drive_item(directed[i], 1'b1);

		// random: alternate fill and drain phases, one stretch without gaps
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				filling = ~filling;
				focus = $urandom_range(NUM_SEQ - 1);
			end
			drive_item(random_item(filling, focus), !(n >= 500 && n < 800));
		end
		@(negedge clk);
		start <= 1'b0;

		// drain the outstanding results
		while (sb.outcome_q.size() != 0 && waited < 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.outcome_q.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived, expected %p, actual none",
				$time, sb.outcome_q.size(), sb.outcome_q[0]);
		end

		$display("run covered %0d operations and %0d checked results", n_sent, sb.checked);
		$display("outcomes: ok %0d, storage full %0d, queue full %0d, %s %0d, %s %0d, %s %0d",
			sb.status_seen[lmqts_pkg::STAT_OK], sb.status_seen[lmqts_pkg::STAT_STORAGE_FULL],
			sb.status_seen[lmqts_pkg::STAT_QUEUE_FULL],
			"invalid", sb.status_seen[lmqts_pkg::STAT_INVALID],
			"locked", sb.status_seen[lmqts_pkg::STAT_LOCKED],
			"empty", sb.status_seen[lmqts_pkg::STAT_EMPTY]);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
